[hdl/bucket_sort_insertion_defines.svh]
// Assertion macros shared by the bucket sorter modules.
`ifndef BUCKET_SORT_INSERTION_DEFINES_SVH
`define BUCKET_SORT_INSERTION_DEFINES_SVH

// Checked property that is ignored while reset is asserted.
`define BSI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds while reset is asserted.
`define BSI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/bsi_pkg.sv]
// Shared types and constants for the bucket sorter.
package bsi_pkg;

  localparam int VALUE_W       = 32;
  localparam int BKT_W         = 6;
  localparam int CFG_W         = 7;
  localparam int MAX_ITEMS_DEF = 64;
  localparam int BUCKET_MAX    = 64;
  localparam int BUCKET_RESET  = 8;
  localparam int SPAN_W        = VALUE_W + 1;
  localparam int BOUND_W       = SPAN_W + BKT_W + 1;
  localparam int ITER_W        = $clog2(SPAN_W);
  localparam int OUT_DATA_W    = ((VALUE_W + BKT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_START,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } chain_ctrl_t;

endpackage

[hdl/bsi_cell.sv]
// One sorting cell: holds one value, inserts in order or shifts toward the head.
module bsi_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bsi_pkg::chain_ctrl_t                 ctrl,
  input  logic signed [bsi_pkg::VALUE_W-1:0]   new_value,
  input  logic                                 prev_valid,
  input  logic                                 prev_le,
  input  logic signed [bsi_pkg::VALUE_W-1:0]   prev_value,
  input  logic                                 next_valid,
  input  logic signed [bsi_pkg::VALUE_W-1:0]   next_value,
  output logic                                 valid,
  output logic                                 le,
  output logic signed [bsi_pkg::VALUE_W-1:0]   value
);

  assign le = valid && (value <= new_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert) begin
      if (!le) begin
        valid <= prev_valid;
      end
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (!le) begin
        value <= prev_le ? new_value : prev_value;
      end
    end else if (ctrl.shift) begin
      value <= next_value;
    end
  end

endmodule

[hdl/bsi_chain.sv]
// Row of sorting cells that keeps the loaded values in ascending order.
`include "bucket_sort_insertion_defines.svh"

module bsi_chain #(
  parameter int MAX_ITEMS = bsi_pkg::MAX_ITEMS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bsi_pkg::chain_ctrl_t                 ctrl,
  input  logic signed [bsi_pkg::VALUE_W-1:0]   new_value,
  output logic signed [bsi_pkg::VALUE_W-1:0]   head_value
);

  logic [MAX_ITEMS-1:0]                      valid;
  logic [MAX_ITEMS-1:0]                      le;
  logic signed [bsi_pkg::VALUE_W-1:0]        value [MAX_ITEMS];

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                               p_valid;
    logic                               p_le;
    logic signed [bsi_pkg::VALUE_W-1:0] p_value;
    logic                               n_valid;
    logic signed [bsi_pkg::VALUE_W-1:0] n_value;

    if (i == 0) begin : g_first
      assign p_valid = 1'b1;
      assign p_le    = 1'b1;
      assign p_value = '0;
    end else begin : g_mid
      assign p_valid = valid[i-1];
      assign p_le    = le[i-1];
      assign p_value = value[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_end
      assign n_valid = 1'b0;
      assign n_value = '0;
    end else begin : g_inner
      assign n_valid = valid[i+1];
      assign n_value = value[i+1];
    end

    bsi_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_value  (new_value),
      .prev_valid (p_valid),
      .prev_le    (p_le),
      .prev_value (p_value),
      .next_valid (n_valid),
      .next_value (n_value),
      .valid      (valid[i]),
      .le         (le[i]),
      .value      (value[i])
    );
  end

  assign head_value = value[0];

  `BSI_ASSERT(a_valid_packed, ((valid >> 1) & ~valid) == '0, "chain has a gap in valid cells")
  `BSI_ASSERT(a_ctrl_excl, !(ctrl.insert && ctrl.shift), "insert and shift requested together")

endmodule

[hdl/bsi_div.sv]
// Serial restoring divider, one quotient bit per cycle.
module bsi_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bsi_pkg::SPAN_W-1:0]    numer,
  input  logic [bsi_pkg::CFG_W-1:0]     denom,
  output logic                          done,
  output logic [bsi_pkg::SPAN_W-1:0]    quot
);

  logic                          busy;
  logic [bsi_pkg::ITER_W-1:0]    iter;
  logic [bsi_pkg::CFG_W-1:0]     rem;
  logic [bsi_pkg::CFG_W:0]       rem_shift;
  logic                          fits;

  assign rem_shift = {rem, quot[bsi_pkg::SPAN_W-1]};
  assign fits      = rem_shift >= {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && iter == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= numer;
      rem  <= '0;
      iter <= bsi_pkg::ITER_W'(bsi_pkg::SPAN_W - 1);
    end else if (busy) begin
      quot <= {quot[bsi_pkg::SPAN_W-2:0], fits};
      rem  <= fits ? bsi_pkg::CFG_W'(rem_shift - {1'b0, denom})
                   : bsi_pkg::CFG_W'(rem_shift);
      iter <= iter - 1'b1;
    end
  end

endmodule

[hdl/bucket_sort_insertion.sv]
// Top level: loads values, sizes the buckets and streams the sorted run out.
// Loading takes one transaction per cycle while in the load state; each kept value enters the
// cell row on acceptance. After the last value a setup state starts the divider for the bucket
// width; the results then stream out, with bucket boundary steps between them as needed.
// Results leave through an output register; the next set may load while it drains.
// Synchronous active-high reset empties the cell row and sets bucket_count to 8.
`include "bucket_sort_insertion_defines.svh"

module bucket_sort_insertion #(
  parameter int MAX_ITEMS = bsi_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bsi_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bsi_pkg::VALUE_W-1:0]       s_axis_tdata,  // value
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bsi_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // sorted_value, bucket_index
  output logic                              m_axis_tlast,
  output logic                              m_axis_tuser   // overflow
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  bsi_pkg::state_t                    state, state_next;
  logic [bsi_pkg::CFG_W-1:0]          bucket_count;
  logic [CNT_W-1:0]                   cnt;
  logic signed [bsi_pkg::VALUE_W-1:0] run_min, run_max;
  logic                               ovf;
  logic [bsi_pkg::SPAN_W-1:0]         width;
  logic [bsi_pkg::BOUND_W-1:0]        bound;
  logic [bsi_pkg::BKT_W-1:0]          bkt;

  logic                               out_valid;
  logic signed [bsi_pkg::VALUE_W-1:0] out_value;
  logic [bsi_pkg::BKT_W-1:0]          out_bkt;
  logic                               out_last;
  logic                               out_ovf;

  logic                               accept, keep;
  logic signed [bsi_pkg::VALUE_W-1:0] in_value;
  logic [bsi_pkg::CFG_W-1:0]          bc_eff;
  logic [bsi_pkg::BKT_W-1:0]          bc_m1;
  logic [bsi_pkg::SPAN_W-1:0]         span, div_num, div_quot, offset;
  logic                               div_start, div_done;
  logic                               advance, emit;
  logic signed [bsi_pkg::VALUE_W-1:0] head_value;
  bsi_pkg::chain_ctrl_t               chain_ctrl;

  assign in_value = s_axis_tdata;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign keep     = cnt < CNT_W'(MAX_ITEMS);

  always_comb begin
    priority if (bucket_count == '0) begin
      bc_eff = bsi_pkg::CFG_W'(1);
    end else if (bucket_count > bsi_pkg::CFG_W'(bsi_pkg::BUCKET_MAX)) begin
      bc_eff = bsi_pkg::CFG_W'(bsi_pkg::BUCKET_MAX);
    end else begin
      bc_eff = bucket_count;
    end
  end
  assign bc_m1 = bsi_pkg::BKT_W'(bc_eff - 1'b1);

  assign span    = {run_max[bsi_pkg::VALUE_W-1], run_max}
                 - {run_min[bsi_pkg::VALUE_W-1], run_min};
  assign div_num = span + bsi_pkg::SPAN_W'(bc_eff);
  assign offset  = {head_value[bsi_pkg::VALUE_W-1], head_value}
                 - {run_min[bsi_pkg::VALUE_W-1], run_min};

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    advance       = 1'b0;
    emit          = 1'b0;
    unique case (state)
      bsi_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (accept && s_axis_tlast) begin
          state_next = bsi_pkg::ST_START;
        end
      end
      bsi_pkg::ST_START: begin
        div_start  = 1'b1;
        state_next = bsi_pkg::ST_DIV;
      end
      bsi_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = bsi_pkg::ST_EMIT;
        end
      end
      bsi_pkg::ST_EMIT: begin
        advance = ({(bsi_pkg::BOUND_W - bsi_pkg::SPAN_W)'(0), offset} >= bound)
                  && (bkt != bc_m1);
        emit    = !advance && (!out_valid || m_axis_tready);
        if (emit && cnt == CNT_W'(1)) begin
          state_next = bsi_pkg::ST_LOAD;
        end
      end
      default: state_next = bsi_pkg::ST_LOAD;
    endcase
  end

  assign chain_ctrl.insert = accept && keep;
  assign chain_ctrl.shift  = emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsi_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= bsi_pkg::CFG_W'(bsi_pkg::BUCKET_RESET);
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      run_min <= '0;
      run_max <= '0;
      ovf     <= 1'b0;
    end else if (accept) begin
      if (keep) begin
        cnt <= cnt + 1'b1;
        if (cnt == '0) begin
          run_min <= in_value;
          run_max <= in_value;
        end else begin
          if (in_value < run_min) begin
            run_min <= in_value;
          end
          if (in_value > run_max) begin
            run_max <= in_value;
          end
        end
      end else begin
        ovf <= 1'b1;
      end
    end else if (emit) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        run_min <= '0;
        run_max <= '0;
        ovf     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == bsi_pkg::ST_DIV && div_done) begin
      width <= div_quot;
      bound <= bsi_pkg::BOUND_W'(div_quot);
      bkt   <= '0;
    end else if (advance) begin
      bound <= bound + bsi_pkg::BOUND_W'(width);
      bkt   <= bkt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value <= head_value;
      out_bkt   <= bkt;
      out_last  <= cnt == CNT_W'(1);
      out_ovf   <= ovf;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(bsi_pkg::OUT_DATA_W - bsi_pkg::VALUE_W - bsi_pkg::BKT_W)'(0),
                          out_bkt, out_value};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_ovf;

  bsi_chain #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (chain_ctrl),
    .new_value  (in_value),
    .head_value (head_value)
  );

  bsi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_num),
    .denom (bc_eff),
    .done  (div_done),
    .quot  (div_quot)
  );

  `BSI_ASSERT(a_cnt_range, cnt <= CNT_W'(MAX_ITEMS), "item count beyond capacity")
  `BSI_ASSERT(a_emit_nonempty, state == bsi_pkg::ST_EMIT |-> cnt != '0, "emitting from an empty set")
  `BSI_ASSERT(a_bkt_range, state == bsi_pkg::ST_EMIT |-> bkt <= bc_m1, "bucket index past last bucket")
  `BSI_ASSERT(a_end_of_run, emit && cnt == CNT_W'(1) |=> state == bsi_pkg::ST_LOAD && cnt == '0, "set not closed after final result")

endmodule

[dv/tb_bucket_sort_insertion.sv]
// Testbench for the bucket sorter: streams value sets in and checks each sorted run.
`timescale 1ns / 1ps

module tb_bucket_sort_insertion;

  localparam int VALUE_W = bsi_pkg::VALUE_W;
  localparam int BKT_W = bsi_pkg::BKT_W;
  localparam int CFG_W = bsi_pkg::CFG_W;
  localparam int OUT_DATA_W = bsi_pkg::OUT_DATA_W;
  localparam int BUCKET_MAX = bsi_pkg::BUCKET_MAX;
  localparam int BUCKET_RESET = bsi_pkg::BUCKET_RESET;
  localparam int NUM_ITEMS = bsi_pkg::MAX_ITEMS_DEF;
  localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [CFG_W-1:0] CFG_ONE = 7'd1;
  localparam logic [CFG_W-1:0] CFG_ZERO = 7'd0;
  localparam logic [CFG_W-1:0] CFG_ALL_ONES = 7'h7f;
  localparam int RANDOM_ITEMS = 104;
  localparam int LONG_HOLD = 500;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [BKT_W-1:0] bkt;
    logic last;
    logic ovf;
  } sorted_item_t;

  class sort_scoreboard;
    logic [VALUE_W-1:0] store[NUM_ITEMS];
    int count;
    int lo;
    int hi;
    bit ovf;
    int buckets;
    int errors;
    sorted_item_t pending_sorted[$];

    function new();
      count = 0;
      lo = 0;
      hi = 0;
      ovf = 0;
      buckets = BUCKET_RESET;
      errors = 0;
    endfunction

    function void set_buckets(logic [CFG_W-1:0] bc);
      buckets = int'(bc);
    endfunction

    function int pending();
      return pending_sorted.size();
    endfunction

    function void load_value(logic [VALUE_W-1:0] raw, logic is_last);
      int v;
      int bc;
      longint span;
      longint width;
      longint b;
      int vals[NUM_ITEMS];
      int bkts[NUM_ITEMS];
      int kv;
      int kb;
      int j;
      sorted_item_t item;
      v = raw;
      if (count < NUM_ITEMS) begin
        if (count == 0) begin
          lo = v;
          hi = v;
        end else begin
          if (v < lo) lo = v;
          if (v > hi) hi = v;
        end
        store[count] = raw;
        count++;
      end else begin
        ovf = 1;
      end
      if (!is_last) return;
      bc = buckets;
      if (bc == 0) bc = 1;
      if (bc > BUCKET_MAX) bc = BUCKET_MAX;
      span = longint'(hi) - longint'(lo);
      width = (span + bc) / bc;
      if (width == 0) width = 1;
      for (int i = 0; i < count; i++) begin
        vals[i] = store[i];
        b = (longint'(vals[i]) - longint'(lo)) / width;
        if (b > bc - 1) b = bc - 1;
        bkts[i] = int'(b);
      end
      // Stable insertion sort keyed on bucket, then value.
      for (int i = 1; i < count; i++) begin
        kv = vals[i];
        kb = bkts[i];
        j = i;
        while (j > 0 && (bkts[j-1] > kb || (bkts[j-1] == kb && vals[j-1] > kv))) begin
          vals[j] = vals[j-1];
          bkts[j] = bkts[j-1];
          j--;
        end
        vals[j] = kv;
        bkts[j] = kb;
      end
      for (int i = 0; i < count; i++) begin
        item.value = vals[i];
        item.bkt = BKT_W'(bkts[i]);
        item.last = (i == count - 1);
        item.ovf = ovf;
        pending_sorted.insert(pending_sorted.size(), item);
      end
      count = 0;
      lo = 0;
      hi = 0;
      ovf = 0;
    endfunction

    function void check_sorted(logic [VALUE_W-1:0] v, logic [BKT_W-1:0] b, logic l,
                               logic o);
      sorted_item_t want;
      if (pending_sorted.size() == 0) begin
        $error("unexpected result: sorted_value %0d", $signed(v));
        errors++;
        return;
      end
      want = pending_sorted.pop_front();
      if (v !== want.value) begin
        $error("sorted_value: expected %0d, actual %0d", $signed(want.value), $signed(v));
        errors++;
      end
      if (b !== want.bkt) begin
        $error("bucket_index: expected %0d, actual %0d", want.bkt, b);
        errors++;
      end
      if (l !== want.last) begin
        $error("last_out: expected %0d, actual %0d", want.last, l);
        errors++;
      end
      if (o !== want.ovf) begin
        $error("overflow: expected %0d, actual %0d", want.ovf, o);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [VALUE_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;

  sort_scoreboard sb = new();
  int burst_left = 0;
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_left = 0;
  int pat_left = 0;
  int pat_mode = 0;

  bucket_sort_insertion dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_sorted(m_axis_tdata[VALUE_W-1:0], m_axis_tdata[VALUE_W+BKT_W-1:VALUE_W],
                      m_axis_tlast, m_axis_tuser);
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (holds_done != hold_reqs) begin
      holds_done++;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 3);
        pat_left = $urandom_range(20, 120);
      end
      pat_left--;
      unique case (pat_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 7) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_item(input logic [VALUE_W-1:0] v, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    s_axis_tlast <= is_last;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    sb.load_value(v, is_last);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_buckets(input logic [CFG_W-1:0] bc);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= bc;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_buckets(bc);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(int flavor, logic [VALUE_W-1:0] base);
    unique case (flavor)
      0: return $urandom;
      1: return base + $urandom_range(0, 15);
      2: begin
        unique case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom_range(0, 100) - 50;
    endcase
  endfunction

  task automatic send_set(input int size);
    int flavor;
    int f;
    logic [VALUE_W-1:0] base;
    flavor = $urandom_range(0, 4);
    base = $urandom;
    for (int i = 0; i < size; i++) begin
      f = (flavor == 4) ? $urandom_range(0, 3) : flavor;
      send_item(pick_value(f, base), i == size - 1);
    end
  endtask

  initial begin
    int sent;
    int phase;
    int size;
    int nsets;
    int plan[4];
    plan = '{BUCKET_MAX, 2, 5, 33};
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset bucket count: single value, full signed span, duplicates.
    send_item(32'd0, 1'b1);
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item(32'd0, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'd1, 1'b1);
    send_item(32'd5, 1'b0);
    send_item(32'd5, 1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(32'd5, 1'b0);
    send_item(-32'sd3, 1'b1);

    write_buckets(CFG_ONE);
    send_item(32'd100, 1'b0);
    send_item(-32'sd100, 1'b0);
    send_item(32'd7, 1'b1);

    write_buckets(CFG_W'(BUCKET_MAX));
    send_item(32'd63, 1'b0);
    send_item(32'd0, 1'b0);
    send_item(32'd1, 1'b0);
    send_item(32'd62, 1'b0);
    send_item(32'd31, 1'b1);
    send_item(VAL_MIN, 1'b0);
    send_item(VAL_MAX, 1'b1);

    // A zero count acts as one bucket; a count above the maximum saturates.
    write_buckets(CFG_ZERO);
    send_item(32'd3, 1'b0);
    send_item(-32'sd9, 1'b1);
    write_buckets(CFG_ALL_ONES);
    send_item(-32'sd5, 1'b0);
    send_item(32'd1000, 1'b0);
    send_item(32'd77, 1'b1);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      write_buckets((phase < 4) ? CFG_W'(plan[phase]) : CFG_W'($urandom_range(0, 127)));
      nsets = $urandom_range(2, 5);
      for (int s = 0; s < nsets && sent < RANDOM_ITEMS; s++) begin
        if (phase == 0 && s == 0) begin
          // Overfill the store while the output is held off.
          hold_reqs++;
          size = NUM_ITEMS + $urandom_range(1, 4);
        end else if ($urandom_range(0, 3) == 0) begin
          size = $urandom_range(13, 40);
        end else begin
          size = $urandom_range(1, 12);
        end
        if (sent + size > RANDOM_ITEMS) size = RANDOM_ITEMS - sent;
        send_set(size);
        sent += size;
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("bucket_sort_insertion test passed");
    end else begin
      $display("bucket_sort_insertion test failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("bucket_sort_insertion test failed");
    $finish;
  end

endmodule
